FILE: rtl/assert_macros.svh
// assertion helpers for the glob matcher
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge of aclk, masked while reset is held
`define WGM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// same check with no reset mask
`define WGM_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

FILE: rtl/wgm_pkg.sv
package wgm_pkg;

    localparam int MAX_PATTERN_LEN_DEF = 32;

    localparam int CHAR_W   = 8;
    localparam int CMD_W    = 2;
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 8;

    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TEXT   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_END    = 2'd3;

    localparam logic [CHAR_W-1:0] STAR_BYTE  = 8'h2A;
    localparam logic [CHAR_W-1:0] QMARK_BYTE = 8'h3F;

endpackage

FILE: rtl/wildcard_glob_matcher.sv
// a match result is offered on m_tdata in the cycle after its end-of-text transfer
// throughput: one input transfer per cycle while s_tready is high, set by the live-position
// update (byte compares plus a log-depth star closure feeding back into the live register)
// reset: aresetn low at a rising edge empties the pattern, clears the overflow flag,
// restarts the live set at position zero and drops any pending result
module wildcard_glob_matcher
    import wgm_pkg::*;
#(
    parameter int MAX_PATTERN_LEN = MAX_PATTERN_LEN_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // [1:0] cmd, [9:2] char_in, rest zero
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata    // [0] matched, [1] pattern_overflow, rest zero
);

`include "assert_macros.svh"

    // pattern positions 0..MAX_PATTERN_LEN
    localparam int NPOS = MAX_PATTERN_LEN + 1;
    localparam int LVLS = $clog2(NPOS);

    // input fields
    logic [CMD_W-1:0]  s_cmd;
    logic [CHAR_W-1:0] s_char;
    logic              s_xfer;

    assign s_cmd  = s_tdata[CMD_W-1:0];
    assign s_char = s_tdata[CMD_W +: CHAR_W];
    assign s_xfer = s_tvalid & s_tready;

    // pattern storage: one byte per entry plus decoded wildcard flags,
    // and a thermometer of occupied entries standing in for the length
    logic [CHAR_W-1:0]          pat_reg [MAX_PATTERN_LEN];
    logic [MAX_PATTERN_LEN-1:0] star_reg;
    logic [MAX_PATTERN_LEN-1:0] qm_reg;
    logic [MAX_PATTERN_LEN-1:0] in_pat_reg, in_pat_next;
    logic                       ovf_reg, ovf_next;

    // live set kept without star closure; closure is taken where it is used
    logic [NPOS-1:0]            raw_reg, raw_next;

    // result register
    logic                       m_valid_reg, m_valid_next;
    logic [M_DATA_W-1:0]        m_data_reg, m_data_next;

    // combinational helpers
    logic [NPOS-1:0]            fill_shift;    // occupancy with a one shifted in
    logic [MAX_PATTERN_LEN-1:0] wr_en;         // entry written by an append
    logic [MAX_PATTERN_LEN-1:0] star_vec;      // live '*' entries of the pattern
    logic [MAX_PATTERN_LEN-1:0] step_vec;      // entries that consume this text byte
    logic [NPOS-1:0]            end_vec;       // one-hot at position pattern_length
    logic [NPOS-1:0]            closed;        // live set after star closure
    logic [NPOS-1:0]            raw_feed;      // live set after one text byte
    logic                       hit;
    logic [NPOS-1:0]            g_lv [LVLS+1];
    logic [NPOS-1:0]            p_lv [LVLS+1];

    assign s_tready = ~m_valid_reg | m_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    assign fill_shift = {in_pat_reg, 1'b1};
    assign wr_en      = (s_xfer && s_cmd == CMD_APPEND) ?
                        (fill_shift[MAX_PATTERN_LEN-1:0] & ~in_pat_reg) : '0;
    assign end_vec    = {in_pat_reg, 1'b1} & ~{1'b0, in_pat_reg};

    always_comb begin
        for (int i = 0; i < MAX_PATTERN_LEN; i++) begin
            star_vec[i] = in_pat_reg[i] & star_reg[i];
            step_vec[i] = in_pat_reg[i] & ~star_reg[i] & (qm_reg[i] | (pat_reg[i] == s_char));
        end
    end

    // star closure as a parallel prefix scan:
    // live[j] |= live[j-1] & star[j-1], resolved in log2 levels
    always_comb begin
        g_lv[0] = raw_reg;
        p_lv[0] = {star_vec, 1'b0};
        for (int l = 0; l < LVLS; l++) begin
            for (int j = 0; j < NPOS; j++) begin
                if (j >= (1 << l)) begin
                    g_lv[l+1][j] = g_lv[l][j] | (p_lv[l][j] & g_lv[l][j - (1 << l)]);
                    p_lv[l+1][j] = p_lv[l][j] & p_lv[l][j - (1 << l)];
                end else begin
                    g_lv[l+1][j] = g_lv[l][j];
                    p_lv[l+1][j] = 1'b0;
                end
            end
        end
        closed = g_lv[LVLS];
    end

    // a star stays live in place, a literal or '?' that matches moves one position on
    assign raw_feed = {1'b0, closed[MAX_PATTERN_LEN-1:0] & star_vec}
                    | {closed[MAX_PATTERN_LEN-1:0] & step_vec, 1'b0};

    assign hit = (|(closed & end_vec)) & ~ovf_reg;

    // state and result update
    always_comb begin
        in_pat_next  = in_pat_reg;
        ovf_next     = ovf_reg;
        raw_next     = raw_reg;
        m_valid_next = m_valid_reg & ~m_tready;
        m_data_next  = m_data_reg;
        if (s_xfer) begin
            case (s_cmd)
                CMD_CLEAR: begin
                    in_pat_next = '0;
                    ovf_next    = 1'b0;
                    raw_next    = NPOS'(1);
                end
                CMD_APPEND: begin
                    // a full pattern drops the byte and flags overflow
                    in_pat_next = fill_shift[MAX_PATTERN_LEN-1:0];
                    if (in_pat_reg[MAX_PATTERN_LEN-1]) begin
                        ovf_next = 1'b1;
                    end
                    raw_next    = NPOS'(1);
                end
                CMD_TEXT: begin
                    raw_next = raw_feed;
                end
                CMD_END: begin
                    raw_next     = NPOS'(1);
                    m_valid_next = 1'b1;
                    m_data_next  = {{(M_DATA_W-2){1'b0}}, ovf_reg, hit};
                end
                default: begin
                    raw_next = raw_reg;
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_pat_reg  <= '0;
            ovf_reg     <= 1'b0;
            raw_reg     <= NPOS'(1);
            m_valid_reg <= 1'b0;
        end else begin
            in_pat_reg  <= in_pat_next;
            ovf_reg     <= ovf_next;
            raw_reg     <= raw_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        for (int i = 0; i < MAX_PATTERN_LEN; i++) begin
            if (wr_en[i]) begin
                pat_reg[i]  <= s_char;
                star_reg[i] <= (s_char == STAR_BYTE);
                qm_reg[i]   <= (s_char == QMARK_BYTE);
            end
        end
    end

    // checks
    `WGM_ASSERT(a_occupancy_contiguous,
        ((in_pat_reg >> 1) & ~in_pat_reg) == '0,
        "pattern occupancy has a hole")
    `WGM_ASSERT(a_overflow_needs_full,
        ovf_reg |-> in_pat_reg[MAX_PATTERN_LEN-1],
        "overflow flagged while pattern not full")
    `WGM_ASSERT(a_end_gives_result,
        (s_xfer && s_cmd == CMD_END) |=> m_valid_reg,
        "end of text transfer produced no result")
    `WGM_ASSERT(a_pattern_change_restarts,
        (s_xfer && (s_cmd == CMD_CLEAR || s_cmd == CMD_APPEND)) |=> raw_reg == NPOS'(1),
        "live set not restarted after pattern change")

endmodule
